// File: rtl/bitmap_block_allocator_macros.svh
// Assertion macros for the bitmap block allocator.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define BBA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: rtl/bba_pkg.sv
// Shared constants, types and helper functions of the bitmap block allocator.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
package bba_pkg;

  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int WORD_W         = 64;
  localparam int POS_W          = 6;
  localparam int CFG_W          = 13;
  localparam int IDX_W          = 12;
  localparam int STS_W          = 3;
  localparam int CNT_W          = 14;

  localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STS_W-1:0] {
    STS_ALLOCATED    = 3'd0,
    STS_NONE_FREE    = 3'd1,
    STS_FREED        = 3'd2,
    STS_ALREADY_FREE = 3'd3,
    STS_OUT_OF_RANGE = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic req_load;
    logic scan_start;
    logic scan_step;
    logic range_fail;
    logic free_read;
    logic free_eval;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic idx_oor;
    logic scan_done;
    logic out_valid;
  } sts_t;

  // Lowest set bit of a word: MSB flags that any bit was set, low bits give its position.
  function automatic logic [POS_W:0] first_set(input logic [WORD_W-1:0] w);
    logic [POS_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = {1'b1, POS_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/bba_req_if.sv
// Request channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg for field widths.
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bba_pkg::IDX_W-1:0]   block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink   (input valid, input operation, input block_index, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
// Response channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg for field widths.
interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::IDX_W-1:0]   result_block;
  logic [bba_pkg::STS_W-1:0]   status;

  modport source (output valid, output result_block, output status, input ready);
  modport sink   (input valid, input result_block, input status, output ready);
endinterface

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bba_ctrl.sv
// Controller of the bitmap block allocator: sequences clearing, scan and free steps.
// Depends on bba_pkg (cmd_t, sts_t) and the assertion macro header.
`include "bitmap_block_allocator_macros.svh"
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          rsp_ready_i,
  input  bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DISPATCH = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_FREE     = 3'd4;
  localparam logic [2:0] ST_DELIVER  = 3'd5;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts_i.op_free) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else if (sts_i.idx_oor) begin
          cmd_o.range_fail = 1'b1;
          state_d          = ST_DELIVER;
        end else begin
          cmd_o.free_read = 1'b1;
          state_d         = ST_FREE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_FREE: begin
        cmd_o.free_eval = 1'b1;
        state_d         = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!sts_i.out_valid || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `BBA_ASSERT(a_accept_dispatches, clk_i, rst_ni, (req_valid_i && req_ready_o) |=> (state_q == ST_DISPATCH), "accepted request did not reach dispatch")
  `BBA_ASSERT(a_load_into_free_slot, clk_i, rst_ni, cmd_o.out_load |-> (!sts_i.out_valid || rsp_ready_i), "result loaded over an untaken result")
  `BBA_ASSERT_NEVER(a_no_accept_while_busy, clk_i, rst_ni, cmd_o.req_load && (cmd_o.clr_step || cmd_o.out_load), "request accepted during clearing or delivery")

endmodule

// File: rtl/bba_dp.sv
// Datapath of the bitmap block allocator: bitmap RAM, scan pointer, range checks,
// first-free search and result registers. Depends on bba_pkg, bba_ram and the macro header.
`include "bitmap_block_allocator_macros.svh"
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        req_operation_i,
  input  logic [bba_pkg::IDX_W-1:0]   req_block_index_i,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic [bba_pkg::IDX_W-1:0]   rsp_result_block_o,
  output logic [bba_pkg::STS_W-1:0]   rsp_status_o,
  input  bba_pkg::cmd_t               cmd_i,
  output bba_pkg::sts_t               sts_o
);

  localparam int WW    = bba_pkg::WORD_W;
  localparam int PW    = bba_pkg::POS_W;
  localparam int WORDS = (MAX_BLOCKS + WW - 1) / WW;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [bba_pkg::CFG_W-1:0] total_q;
  logic                      op_q;
  logic [bba_pkg::IDX_W-1:0] idx_q;
  logic [AW-1:0]             wptr_q;
  logic [AW-1:0]             clr_cnt_q;
  logic [bba_pkg::IDX_W-1:0] pend_block_q;
  bba_pkg::status_e          pend_status_q;
  logic                      out_valid_q;
  logic [bba_pkg::IDX_W-1:0] out_block_q;
  bba_pkg::status_e          out_status_q;

  logic [bba_pkg::CNT_W-1:0] count;
  logic [31:0]               base;
  logic [31:0]               lim;
  logic [WW-1:0]             range_mask;
  logic [WW-1:0]             free_bits;
  logic [PW:0]               first;
  logic                      found;
  logic                      last_word;
  logic [31:0]               alloc_blk;
  logic [AW-1:0]             idx_word;
  logic [WW-1:0]             idx_bit;
  logic                      idx_used;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  // A count above the capacity saturates to the capacity.
  always_comb begin
    if (32'(total_q) > MAX_BLOCKS) begin
      count = bba_pkg::CNT_W'(MAX_BLOCKS);
    end else begin
      count = bba_pkg::CNT_W'(total_q);
    end
  end

  // Only bits of the current word that lie below the active count take part in the search.
  assign base = 32'(wptr_q) << PW;
  assign lim  = 32'(count) - base;

  always_comb begin
    if (base >= 32'(count)) begin
      range_mask = '0;
    end else if (lim >= 32'(WW)) begin
      range_mask = '1;
    end else begin
      range_mask = (WW'(1) << lim[PW-1:0]) - WW'(1);
    end
  end

  assign free_bits = ~ram_rdata & range_mask;
  assign first     = bba_pkg::first_set(free_bits);
  assign found     = first[PW];
  assign last_word = ((base + 32'(WW)) >= 32'(count)) || (wptr_q == AW'(WORDS - 1));
  assign alloc_blk = base + 32'(first[PW-1:0]);

  assign idx_word = AW'(idx_q[bba_pkg::IDX_W-1:PW]);
  assign idx_bit  = WW'(1) << idx_q[PW-1:0];
  assign idx_used = ram_rdata[idx_q[PW-1:0]];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (cmd_i.scan_step && found) begin
      ram_we    = 1'b1;
      ram_waddr = wptr_q;
      ram_wdata = ram_rdata | (WW'(1) << first[PW-1:0]);
    end else if (cmd_i.free_eval && idx_used) begin
      ram_we    = 1'b1;
      ram_waddr = idx_word;
      ram_wdata = ram_rdata & ~idx_bit;
    end else if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end
  end

  // The scan reads one word ahead so that a word is evaluated every cycle.
  always_comb begin
    ram_raddr = '0;
    if (cmd_i.scan_step) begin
      ram_raddr = wptr_q + 1'b1;
    end else if (cmd_i.free_read) begin
      ram_raddr = idx_word;
    end
  end

  bba_ram #(
    .WIDTH (WW),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= bba_pkg::TOTAL_RESET;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q  <= req_operation_i;
      idx_q <= req_block_index_i;
    end
    if (cmd_i.scan_start) begin
      wptr_q <= '0;
    end else if (cmd_i.scan_step) begin
      wptr_q <= wptr_q + 1'b1;
    end
    if (cmd_i.scan_step && found) begin
      pend_block_q  <= alloc_blk[bba_pkg::IDX_W-1:0];
      pend_status_q <= bba_pkg::STS_ALLOCATED;
    end else if (cmd_i.scan_step) begin
      pend_block_q  <= '0;
      pend_status_q <= bba_pkg::STS_NONE_FREE;
    end else if (cmd_i.range_fail) begin
      pend_block_q  <= '0;
      pend_status_q <= bba_pkg::STS_OUT_OF_RANGE;
    end else if (cmd_i.free_eval) begin
      pend_block_q  <= '0;
      pend_status_q <= idx_used ? bba_pkg::STS_FREED : bba_pkg::STS_ALREADY_FREE;
    end
    if (cmd_i.out_load) begin
      out_block_q  <= pend_block_q;
      out_status_q <= pend_status_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = (clr_cnt_q == AW'(WORDS - 1));
    sts_o.op_free   = (op_q == bba_pkg::OP_FREE);
    sts_o.idx_oor   = (bba_pkg::CNT_W'(idx_q) >= count);
    sts_o.scan_done = found || last_word;
    sts_o.out_valid = out_valid_q;
  end

  assign rsp_valid_o        = out_valid_q;
  assign rsp_result_block_o = out_block_q;
  assign rsp_status_o       = out_status_q;

  `BBA_ASSERT(a_update_flips_one_bit, clk_i, rst_ni, (ram_we && !cmd_i.clr_step) |-> ($countones(ram_wdata ^ ram_rdata) == 1), "bitmap update changed other than one bit")
  `BBA_ASSERT(a_alloc_below_count, clk_i, rst_ni, (cmd_i.scan_step && found) |-> (alloc_blk < 32'(count)), "allocated block at or above the active count")

endmodule

// File: rtl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ctrl and bba_dp.
//
//   channel   dir  handshake          payload
//   req_i     in   valid/ready        operation, block_index
//   rsp_o     out  valid/ready        result_block, status
//   cfg       in   cfg_we_i           cfg_wdata_i (total_blocks)
//
// After reset a clearing pass writes all ceil(MAX_BLOCKS/64) words of the bitmap (64 at the
// default size), one 64-bit word a cycle; requests wait until it ends.
// An allocate scans the 64-bit words up to the first with a free block or the last in range;
// a free reads and then evaluates its word, or with an out-of-range index goes straight to delivery.
// The result sits in an output register; a new request is accepted while it waits,
// and a further result is held back until the earlier one is taken.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata_i,
  bba_req_if.sink                   req_i,
  bba_rsp_if.source                 rsp_o
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .req_operation_i    (req_i.operation),
    .req_block_index_i  (req_i.block_index),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_result_block_o (rsp_o.result_block),
    .rsp_status_o       (rsp_o.status),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule
